// ===== rtl/rsb_pkg.sv =====
`default_nettype none

package rsb_pkg;

  // Width of the bits_marked result field
  localparam int unsigned COUNT_W = 32;

  // Operation codes carried on the input tuser
  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TEST = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PREP,
    ST_WALK,
    ST_DRAIN,
    ST_TREAD,
    ST_DONE
  } rsb_state_t;

  // Result handed from the sequencer to the output register
  typedef struct packed {
    logic               valid;
    logic [COUNT_W-1:0] bits_marked;
    logic               bit_present;
  } rsb_res_t;

endpackage

`default_nettype wire

// ===== rtl/rsb_store.sv =====
`default_nettype none

module rsb_store #(
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned AW        = 10
) (
  input  wire                  clk,
  input  wire                  rst_n,
  output logic                 ready,
  input  wire                  rd_en,
  input  wire  [AW-1:0]        rd_addr,
  output logic [WORD_BITS-1:0] rd_data,
  input  wire                  wr_en,
  input  wire  [AW-1:0]        wr_addr,
  input  wire  [WORD_BITS-1:0] wr_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 clearing_r;
  logic                 clearing_nxt;
  logic [AW-1:0]        clr_addr_r;
  logic [AW-1:0]        clr_addr_nxt;
  logic                 we;
  logic [AW-1:0]        wa;
  logic [WORD_BITS-1:0] wd;

  // The clearing pass owns the write port until every word is zero.
  always_comb begin
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
    we = clearing_r | wr_en;
    wa = clearing_r ? clr_addr_r : wr_addr;
    wd = clearing_r ? '0 : wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign ready   = ~clearing_r;

endmodule

`default_nettype wire

// ===== rtl/rsb_ctrl.sv =====
`default_nettype none

module rsb_ctrl #(
  parameter int unsigned MAP_BITS  = 65536,
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned AW        = 10
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  store_ready,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire                  in_op,
  input  wire  [31:0]          in_idx,
  input  wire  [31:0]          in_len,
  output rsb_pkg::rsb_res_t    res,
  input  wire                  res_ready,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  input  wire  [WORD_BITS-1:0] rd_data,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [WORD_BITS-1:0] wr_data
);

  localparam int unsigned WW = $clog2(WORD_BITS);
  localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};

  rsb_pkg::rsb_state_t state_r, state_nxt;

  logic                 op_r, op_nxt;
  logic [31:0]          idx_r, idx_nxt;
  logic [31:0]          len_r, len_nxt;
  logic [31:0]          last_r, last_nxt;
  logic                 ok_r, ok_nxt;
  logic [31:0]          highest_r, highest_nxt;
  logic [AW-1:0]        w0_r, w0_nxt;
  logic [AW-1:0]        w1_r, w1_nxt;
  logic [AW-1:0]        cur_w_r, cur_w_nxt;
  logic [WORD_BITS-1:0] first_mask_r, first_mask_nxt;
  logic [WORD_BITS-1:0] last_mask_r, last_mask_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  logic [AW-1:0]        pend_addr_r, pend_addr_nxt;
  logic [31:0]          marked_r, marked_nxt;
  logic                 present_r, present_nxt;
  logic [32:0]          last_full;
  logic                 test_out;
  logic [WORD_BITS-1:0] mask;

  assign last_full = {1'b0, idx_r} + {1'b0, len_r} - 33'd1;
  assign test_out  = (idx_r > highest_r) || (idx_r >= 32'(MAP_BITS));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rsb_pkg::ST_IDLE:  if (in_valid && in_ready) state_nxt = rsb_pkg::ST_CHECK;
      rsb_pkg::ST_CHECK: begin
        if (op_r == rsb_pkg::OP_TEST) begin
          state_nxt = test_out ? rsb_pkg::ST_DONE : rsb_pkg::ST_TREAD;
        end else begin
          state_nxt = ok_nxt ? rsb_pkg::ST_PREP : rsb_pkg::ST_DONE;
        end
      end
      rsb_pkg::ST_PREP:  state_nxt = rsb_pkg::ST_WALK;
      rsb_pkg::ST_WALK:  if (cur_w_r == w1_r) state_nxt = rsb_pkg::ST_DRAIN;
      rsb_pkg::ST_DRAIN: state_nxt = rsb_pkg::ST_DONE;
      rsb_pkg::ST_TREAD: state_nxt = rsb_pkg::ST_DONE;
      rsb_pkg::ST_DONE:  if (res_ready) state_nxt = rsb_pkg::ST_IDLE;
      default:           state_nxt = rsb_pkg::ST_IDLE;
    endcase
  end

  // Outputs to the store and the channels
  always_comb begin
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = cur_w_r;
    res.valid = 1'b0;
    unique case (state_r)
      rsb_pkg::ST_IDLE:  in_ready = store_ready;
      rsb_pkg::ST_CHECK: begin
        rd_addr = idx_r[WW +: AW];
        rd_en   = (op_r == rsb_pkg::OP_TEST) && !test_out;
      end
      rsb_pkg::ST_WALK:  rd_en = 1'b1;
      rsb_pkg::ST_DONE:  res.valid = 1'b1;
      default: ;
    endcase
    res.bits_marked = marked_r;
    res.bit_present = present_r;

    mask = ALL_ONES;
    if (pend_addr_r == w0_r) mask = mask & first_mask_r;
    if (pend_addr_r == w1_r) mask = mask & last_mask_r;
    wr_en   = pend_valid_r;
    wr_addr = pend_addr_r;
    wr_data = rd_data | mask;
  end

  // Datapath
  always_comb begin
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    len_nxt        = len_r;
    last_nxt       = last_r;
    ok_nxt         = (len_r != 32'd0) && (last_full < 33'(MAP_BITS));
    highest_nxt    = highest_r;
    w0_nxt         = w0_r;
    w1_nxt         = w1_r;
    cur_w_nxt      = cur_w_r;
    first_mask_nxt = first_mask_r;
    last_mask_nxt  = last_mask_r;
    pend_valid_nxt = 1'b0;
    pend_addr_nxt  = cur_w_r;
    marked_nxt     = marked_r;
    present_nxt    = present_r;
    unique case (state_r)
      rsb_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          op_nxt  = in_op;
          idx_nxt = in_idx;
          len_nxt = in_len;
        end
      end
      rsb_pkg::ST_CHECK: begin
        marked_nxt  = 32'd0;
        present_nxt = 1'b0;
        last_nxt    = last_full[31:0];
        if (op_r == rsb_pkg::OP_SET && ok_nxt) begin
          marked_nxt = len_r;
          if (last_full[31:0] > highest_r) highest_nxt = last_full[31:0];
        end
      end
      rsb_pkg::ST_PREP: begin
        w0_nxt         = idx_r[WW +: AW];
        w1_nxt         = last_r[WW +: AW];
        cur_w_nxt      = idx_r[WW +: AW];
        first_mask_nxt = ALL_ONES << idx_r[WW-1:0];
        last_mask_nxt  = ALL_ONES >> (WW'(WORD_BITS - 1) - last_r[WW-1:0]);
      end
      rsb_pkg::ST_WALK: begin
        pend_valid_nxt = 1'b1;
        cur_w_nxt      = cur_w_r + AW'(1);
      end
      rsb_pkg::ST_TREAD: present_nxt = rd_data[idx_r[WW-1:0]];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rsb_pkg::ST_IDLE;
      highest_r    <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      highest_r    <= highest_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    idx_r        <= idx_nxt;
    len_r        <= len_nxt;
    last_r       <= last_nxt;
    ok_r         <= ok_nxt;
    w0_r         <= w0_nxt;
    w1_r         <= w1_nxt;
    cur_w_r      <= cur_w_nxt;
    first_mask_r <= first_mask_nxt;
    last_mask_r  <= last_mask_nxt;
    pend_addr_r  <= pend_addr_nxt;
    marked_r     <= marked_nxt;
    present_r    <= present_nxt;
  end

  // A write back always follows a read issued by the walk.
  a_write_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> $past(state_r == rsb_pkg::ST_WALK))
    else $error("write back without a preceding walk read");

  // The walk never passes the last word of the run.
  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rsb_pkg::ST_WALK) |-> (cur_w_r <= w1_r && cur_w_r >= w0_r))
    else $error("walk address outside the run");

  // A bit test samples data read in the cycle before.
  a_test_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rsb_pkg::ST_TREAD) |-> $past(rd_en))
    else $error("bit test without a store read");

  // Only a successful set walks the store.
  a_set_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rsb_pkg::ST_PREP) |-> (ok_r && op_r == rsb_pkg::OP_SET))
    else $error("walk started for a rejected request");

endmodule

`default_nettype wire

// ===== rtl/range_set_bitmap.sv =====
// Sequence: a set passes through check, mask set-up, one read per storage word it covers,
// drain of the last write back and hand-off; a test through check, bit read and hand-off,
// and a rejected set or a test out of range through check and hand-off. One request is
// taken at a time, and the sequencer returns to idle after each hand-off.
// Reset: synchronous, active low; a clearing pass then zeroes all MAP_BITS / WORD_BITS
// storage words, during which in_tready stays low.
`default_nettype none

module range_set_bitmap #(
  parameter int unsigned MAP_BITS  = 65536,
  parameter int unsigned WORD_BITS = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,   // bit_index [31:0], run_length [63:32]
  input  wire         in_tuser,   // operation: 0 set a run, 1 test a bit
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata   // bits_marked [31:0], bit_present [32], zeros above
);

  // WORD_BITS must be a power of two and MAP_BITS a multiple of it; the block does not check.
  localparam int unsigned DEPTH = MAP_BITS / WORD_BITS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  rsb_pkg::rsb_res_t    res;
  logic                 res_ready;
  logic                 store_ready;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_marked_r, out_marked_nxt;
  logic        out_present_r, out_present_nxt;

  rsb_store #(
    .WORD_BITS (WORD_BITS),
    .DEPTH     (DEPTH),
    .AW        (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ready   (store_ready),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  rsb_ctrl #(
    .MAP_BITS  (MAP_BITS),
    .WORD_BITS (WORD_BITS),
    .AW        (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .store_ready (store_ready),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_op       (in_tuser),
    .in_idx      (in_tdata[31:0]),
    .in_len      (in_tdata[63:32]),
    .res         (res),
    .res_ready   (res_ready),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  // The output register lets the sequencer take the next word while a
  // finished result is still waiting downstream.
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_marked_nxt  = out_marked_r;
    out_present_nxt = out_present_r;
    if (res.valid && res_ready) begin
      out_valid_nxt   = 1'b1;
      out_marked_nxt  = res.bits_marked;
      out_present_nxt = res.bit_present;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_marked_r  <= out_marked_nxt;
    out_present_r <= out_present_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_present_r, out_marked_r};

endmodule

`default_nettype wire
